FILE: rtl/core/bitmap_block_allocator_defines.svh
// Assertion macros used by the bitmap block allocator checker.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bba_pkg.sv
// Types and constants shared by the bitmap block allocator modules.
package bba_pkg;

  localparam int WORD_BITS = 32;
  localparam int WORD_SH   = 5;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int OP_W      = 3;
  localparam logic [CNT_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_RANGE = 3'd2,
    OP_FIND  = 3'd3,
    OP_COUNT = 3'd4
  } bba_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PREP,
    ST_SCAN,
    ST_RESULT
  } bba_state_t;

  typedef struct packed {
    logic clear_word;
    logic capture;
    logic prep;
    logic step;
    logic finish;
  } bba_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic skip;
    logic last;
  } bba_sts_t;

endpackage

FILE: rtl/core/bitmap_block_allocator.sv
// Top level of the bitmap block allocator: controller and datapath.
//
//   Channel   Handshake            Payload
//   command   start / busy         operation, first_index, last_index, bit_value, run_length
//   result    done (strobe)        bit_read, index_valid, run_found, run_start,
//                                  free_bits, used_count
//   config    cfg_valid/cfg_ready  cfg_data (bits_in_use)
//
// The bitmap is held as words of 32 bits in a single memory with one write and one
// registered read port; every operation walks the words it touches one per cycle.
// A command transaction visits the words it needs: single-bit reads and writes visit one,
// searches and counts the words up to the active size, range writes the words in the
// clipped range, and operations with nothing to do visit none.
// A search stops at the word where the first run completes.
// The result shows on done for one cycle, and the next command may be taken in that cycle.
// After reset a clearing pass writes every word to free with busy held high;
// configuration writes are taken throughout.
// Results cannot be stalled by the receiver, so nothing waits on the result side.
module bitmap_block_allocator #(
  parameter int NBITS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [bba_pkg::OP_W-1:0]  operation,
  input  logic [bba_pkg::IDX_W-1:0] first_index,
  input  logic [bba_pkg::IDX_W-1:0] last_index,
  input  logic                      bit_value,
  input  logic [bba_pkg::CNT_W-1:0] run_length,
  output logic                      done,
  output logic                      bit_read,
  output logic                      index_valid,
  output logic                      run_found,
  output logic [bba_pkg::IDX_W-1:0] run_start,
  output logic [bba_pkg::CNT_W-1:0] free_bits,
  output logic [bba_pkg::CNT_W-1:0] used_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bba_pkg::CNT_W-1:0] cfg_data
);

  bba_pkg::bba_cmd_t cmd;
  bba_pkg::bba_sts_t sts;

  // The size register may be written at any time the block is idle.
  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bba_datapath #(
    .NBITS (NBITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .first_index (first_index),
    .last_index  (last_index),
    .bit_value   (bit_value),
    .run_length  (run_length),
    .cmd         (cmd),
    .sts         (sts),
    .bit_read    (bit_read),
    .index_valid (index_valid),
    .run_found   (run_found),
    .run_start   (run_start),
    .free_bits   (free_bits),
    .used_count  (used_count)
  );

endmodule

FILE: rtl/core/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bba_pkg::bba_sts_t sts,
  output bba_pkg::bba_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  bba_pkg::bba_state_t state;
  bba_pkg::bba_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      bba_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = bba_pkg::ST_PREP;
        end
      end
      bba_pkg::ST_CLEAR: begin
        cmd.clear_word = 1'b1;
        if (sts.clear_done) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
        if (sts.skip) begin
          cmd.finish = 1'b1;
          state_next = bba_pkg::ST_RESULT;
        end else begin
          state_next = bba_pkg::ST_SCAN;
        end
      end
      bba_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          cmd.finish = 1'b1;
          state_next = bba_pkg::ST_RESULT;
        end
      end
      bba_pkg::ST_RESULT: begin
        busy = 1'b0;
        done = 1'b1;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = bba_pkg::ST_PREP;
        end else begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/bba_datapath.sv
// Datapath of the bitmap block allocator: word memory, scan logic and result registers.
module bba_datapath #(
  parameter int NBITS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr,
  input  logic [bba_pkg::CNT_W-1:0]    cfg_data,
  input  logic [bba_pkg::OP_W-1:0]     operation,
  input  logic [bba_pkg::IDX_W-1:0]    first_index,
  input  logic [bba_pkg::IDX_W-1:0]    last_index,
  input  logic                         bit_value,
  input  logic [bba_pkg::CNT_W-1:0]    run_length,
  input  bba_pkg::bba_cmd_t            cmd,
  output bba_pkg::bba_sts_t            sts,
  output logic                         bit_read,
  output logic                         index_valid,
  output logic                         run_found,
  output logic [bba_pkg::IDX_W-1:0]    run_start,
  output logic [bba_pkg::CNT_W-1:0]    free_bits,
  output logic [bba_pkg::CNT_W-1:0]    used_count
);

  localparam int WB     = bba_pkg::WORD_BITS;
  localparam int SH     = bba_pkg::WORD_SH;
  localparam int NWORDS = (NBITS + WB - 1) / WB;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW     = (AW + SH + 1 > 12) ? AW + SH + 1 : 12;
  localparam int PW     = $clog2(WB + 1);
  localparam logic [CW-1:0] ONE_C  = 1;
  localparam logic [AW-1:0] LAST_W = AW'(NWORDS - 1);

  // Operand and configuration registers.
  logic [bba_pkg::OP_W-1:0]  op;
  logic [bba_pkg::IDX_W-1:0] first;
  logic [bba_pkg::IDX_W-1:0] last;
  logic                      val;
  logic [bba_pkg::CNT_W-1:0] want;
  logic [bba_pkg::CNT_W-1:0] bits_in_use;

  // Memory and scan state.
  logic [WB-1:0] mem [NWORDS];
  logic [WB-1:0] q;
  logic [AW-1:0] clr;
  logic [AW-1:0] cur;
  logic [CW-1:0] start_r;
  logic [CW-1:0] used_acc;

  logic [bba_pkg::CNT_W-1:0] size;
  logic [CW-1:0] size_c, first_c, last_c, lo_c, hi_c, hi_end, wlo_c, whi_c, base_c;
  logic [AW-1:0] w_lo, w_hi, rd_addr;
  logic          skip, is_write;

  logic [WB-1:0]            inact, wmask, fbits, hit;
  logic [5:0][WB-1:0]       lv;
  logic [5:0][WB-1:0][SH-1:0] lp;
  logic [WB-1:0][CW-1:0]    st;
  logic [CW-1:0]            len, g, hit_start, used_tot;
  logic [PW-1:0]            pop;
  logic                     any_hit;

  logic                      bit_read_next, index_valid_next, run_found_next;
  logic [bba_pkg::IDX_W-1:0] run_start_next;
  logic [bba_pkg::CNT_W-1:0] free_next, used_next;

  // Active size is the size register clamped to the memory size.
  always_comb begin
    if ({21'b0, bits_in_use} > 32'(NBITS)) begin
      size = bba_pkg::CNT_W'(NBITS);
    end else begin
      size = bits_in_use;
    end
  end

  assign size_c  = CW'(size);
  assign first_c = CW'(first);
  assign last_c  = CW'(last);
  assign base_c  = CW'({cur, {SH{1'b0}}});

  always_comb begin
    skip   = 1'b1;
    lo_c   = first_c;
    hi_c   = first_c;
    hi_end = '0;
    wlo_c  = '0;
    whi_c  = '0;
    case (op)
      bba_pkg::OP_READ, bba_pkg::OP_WRITE: begin
        skip  = !(first_c < size_c);
        wlo_c = first_c >> SH;
        whi_c = first_c >> SH;
      end
      bba_pkg::OP_RANGE: begin
        hi_end = (last_c < size_c) ? last_c : size_c - ONE_C;
        hi_c   = last_c;
        skip   = (first_c > last_c) || !(first_c < size_c);
        wlo_c  = first_c >> SH;
        whi_c  = hi_end >> SH;
      end
      bba_pkg::OP_FIND: begin
        skip  = (size == '0) || (want == '0);
        whi_c = (size_c - ONE_C) >> SH;
      end
      bba_pkg::OP_COUNT: begin
        skip  = (size == '0);
        whi_c = (size_c - ONE_C) >> SH;
      end
      default: begin
        skip = 1'b1;
      end
    endcase
    if (skip) begin
      wlo_c = '0;
      whi_c = '0;
    end
  end

  assign w_lo     = AW'(wlo_c);
  assign w_hi     = AW'(whi_c);
  assign is_write = (op == bba_pkg::OP_WRITE) || (op == bba_pkg::OP_RANGE);
  assign rd_addr  = cmd.prep ? w_lo : ((cur == w_hi) ? cur : cur + 1'b1);

  // Per-bit masks of the word being scanned.
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      g        = base_c + CW'(j);
      inact[j] = !(g < size_c);
      wmask[j] = (g >= lo_c) && (g <= hi_c) && !inact[j];
    end
  end

  // Bits past the active size count as used for the search and not at all for the count.
  assign fbits = q | inact;
  assign pop   = PW'($countones(q & ~inact));

  // Prefix scan: position of the highest used bit at or below each bit of the word.
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      lv[0][j] = fbits[j];
      lp[0][j] = SH'(j);
    end
    for (int l = 0; l < SH; l++) begin
      for (int j = 0; j < WB; j++) begin
        if (j >= (1 << l) && !lv[l][j]) begin
          lv[l+1][j] = lv[l][j - (1 << l)];
          lp[l+1][j] = lp[l][j - (1 << l)];
        end else begin
          lv[l+1][j] = lv[l][j];
          lp[l+1][j] = lp[l][j];
        end
      end
    end
  end

  // A free run ending at bit j starts after the last used bit, or where the carried run began.
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      st[j]  = lv[SH][j] ? base_c + CW'(lp[SH][j]) + ONE_C : start_r;
      len    = base_c + CW'(j) + ONE_C - st[j];
      hit[j] = (len >= CW'(want));
    end
  end

  always_comb begin
    hit_start = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_start = st[j];
      end
    end
  end

  assign any_hit  = |hit;
  assign used_tot = used_acc + CW'(pop);

  assign sts.clear_done = (clr == LAST_W);
  assign sts.skip       = skip;
  assign sts.last       = (cur == w_hi) || ((op == bba_pkg::OP_FIND) && any_hit);

  always_comb begin
    bit_read_next    = 1'b0;
    index_valid_next = 1'b0;
    run_found_next   = 1'b0;
    run_start_next   = '0;
    free_next        = '0;
    used_next        = '0;
    if (!skip) begin
      case (op)
        bba_pkg::OP_READ: begin
          bit_read_next    = q[first[SH-1:0]];
          index_valid_next = 1'b1;
        end
        bba_pkg::OP_WRITE: begin
          index_valid_next = 1'b1;
        end
        bba_pkg::OP_FIND: begin
          run_found_next = any_hit;
          run_start_next = any_hit ? hit_start[bba_pkg::IDX_W-1:0] : '0;
        end
        bba_pkg::OP_COUNT: begin
          used_next = bba_pkg::CNT_W'(used_tot);
          free_next = bba_pkg::CNT_W'(size_c - used_tot);
        end
        default: begin
          bit_read_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr         <= '0;
      bits_in_use <= bba_pkg::SIZE_RESET;
    end else begin
      if (cfg_wr) begin
        bits_in_use <= cfg_data;
      end
      if (cmd.clear_word) begin
        clr <= clr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= operation;
      first <= first_index;
      last  <= last_index;
      val   <= bit_value;
      want  <= run_length;
    end
    if (cmd.prep) begin
      cur      <= w_lo;
      start_r  <= '0;
      used_acc <= '0;
    end
    if (cmd.step) begin
      cur      <= rd_addr;
      used_acc <= used_tot;
      if (lv[SH][WB-1]) begin
        start_r <= base_c + CW'(lp[SH][WB-1]) + ONE_C;
      end
    end
    if (cmd.finish) begin
      bit_read    <= bit_read_next;
      index_valid <= index_valid_next;
      run_found   <= run_found_next;
      run_start   <= run_start_next;
      free_bits   <= free_next;
      used_count  <= used_next;
    end
  end

  // Word memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.clear_word) begin
      mem[clr] <= '0;
    end else if (cmd.step && is_write) begin
      mem[cur] <= (q & ~wmask) | (val ? wmask : '0);
    end
  end

  always_ff @(posedge clk) begin
    q <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/bba_checker.sv
// Port-level checker for the bitmap block allocator and its bind.
`include "bitmap_block_allocator_defines.svh"

module bba_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic                      bit_read,
  input logic                      index_valid,
  input logic                      run_found,
  input logic [bba_pkg::CNT_W-1:0] free_bits,
  input logic [bba_pkg::CNT_W-1:0] used_count
);

  `BBA_ASSERT_NEXT(a_no_instant_result, start && !busy, !done,
                   "result in the cycle after a command")
  `BBA_ASSERT_NEXT(a_single_strobe, done, !done,
                   "result strobe held for more than one cycle")
  `BBA_ASSERT_NOW(a_find_fields_alone, done && run_found,
                  !bit_read && !index_valid && free_bits == '0 && used_count == '0,
                  "unused fields set on a search result")
  `BBA_ASSERT_NOW(a_read_implies_valid, done && bit_read, index_valid,
                  "bit read as used at an invalid index")
  `BBA_ASSERT_NOW(a_clear_after_reset, $fell(rst), busy,
                  "block not busy clearing after reset")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bitmap block allocator: directed and random commands.
module testbench;

  localparam int NBITS = 1024;
  // Operation codes that the block does not define; they must leave the bitmap alone.
  localparam logic [bba_pkg::OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [bba_pkg::OP_W-1:0] OP_RESERVED_LAST  = 3'd7;
  // The longest command walks all 32 words of the map.
  localparam int DRAIN_CYCLES    = 60;
  localparam int ITEMS_PER_PHASE = 70;

  // One expected result transaction, one member per result port.
  typedef struct packed {
    logic                      bit_read;
    logic                      index_valid;
    logic                      run_found;
    logic [bba_pkg::IDX_W-1:0] run_start;
    logic [bba_pkg::CNT_W-1:0] free_bits;
    logic [bba_pkg::CNT_W-1:0] used_count;
  } alloc_result_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [bba_pkg::OP_W-1:0]  operation;
  logic [bba_pkg::IDX_W-1:0] first_index;
  logic [bba_pkg::IDX_W-1:0] last_index;
  logic                      bit_value;
  logic [bba_pkg::CNT_W-1:0] run_length;
  logic                      done;
  logic                      bit_read;
  logic                      index_valid;
  logic                      run_found;
  logic [bba_pkg::IDX_W-1:0] run_start;
  logic [bba_pkg::CNT_W-1:0] free_bits;
  logic [bba_pkg::CNT_W-1:0] used_count;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [bba_pkg::CNT_W-1:0] cfg_data;

  // Our own copy of the allocation map and of the size register.
  bit          shadow_map [NBITS];
  int unsigned shadow_size_reg;

  // Results still owed by the block, oldest first.
  alloc_result_t pending_results[$];
  int            error_count;

  bitmap_block_allocator #(.NBITS(NBITS)) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .first_index (first_index),
    .last_index  (last_index),
    .bit_value   (bit_value),
    .run_length  (run_length),
    .done        (done),
    .bit_read    (bit_read),
    .index_valid (index_valid),
    .run_found   (run_found),
    .run_start   (run_start),
    .free_bits   (free_bits),
    .used_count  (used_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // The register may hold more than the map has cells; the excess is simply ignored.
  function automatic int unsigned active_cells();
    return (shadow_size_reg > NBITS) ? NBITS : shadow_size_reg;
  endfunction

  // First-fit search over the active cells. A zero length never matches, and a run
  // is reported at the lowest start whose free stretch first reaches the length.
  function automatic void first_fit(input int unsigned want, output bit found,
                                    output int unsigned where);
    int unsigned run_len;
    int unsigned run_base;
    found = 1'b0;
    where = 0;
    run_len = 0;
    run_base = 0;
    if (want != 0) begin
      for (int unsigned i = 0; i < active_cells(); i++) begin
        if (!shadow_map[i]) begin
          run_len++;
          if (run_len == want) begin
            found = 1'b1;
            where = run_base;
            break;
          end
        end else begin
          run_len = 0;
          run_base = i + 1;
        end
      end
    end
  endfunction

  // Applies one command to the shadow map and returns the result the block owes for it.
  function automatic alloc_result_t apply_command(input logic [bba_pkg::OP_W-1:0] op,
                                                  input int unsigned first,
                                                  input int unsigned last,
                                                  input bit value, input int unsigned want);
    alloc_result_t res;
    int unsigned   size;
    int unsigned   nfree;
    int unsigned   nused;
    bit            found;
    int unsigned   where;
    res = '0;
    size = active_cells();
    case (op)
      bba_pkg::OP_READ: begin
        if (first < size) begin
          res.bit_read = shadow_map[first];
          res.index_valid = 1'b1;
        end
      end
      bba_pkg::OP_WRITE: begin
        if (first < size) begin
          shadow_map[first] = value;
          res.index_valid = 1'b1;
        end
      end
      bba_pkg::OP_RANGE: begin
        // An inverted range does nothing; otherwise the range is clipped to the active size.
        for (int unsigned i = first; i <= last && i < size; i++)
          shadow_map[i] = value;
      end
      bba_pkg::OP_FIND: begin
        first_fit(want, found, where);
        res.run_found = found;
        res.run_start = where[bba_pkg::IDX_W-1:0];
      end
      bba_pkg::OP_COUNT: begin
        nfree = 0;
        for (int unsigned i = 0; i < size; i++)
          if (!shadow_map[i])
            nfree++;
        nused = size - nfree;
        res.free_bits = nfree[bba_pkg::CNT_W-1:0];
        res.used_count = nused[bba_pkg::CNT_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly short gaps, now and then a long one; none at all when idling is switched off.
  function automatic int pick_gap(input bit idle_on);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 50)
      return 0;
    if (roll < 85)
      return $urandom_range(1, 3);
    if (roll < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one command and holds it until the block takes it. The caller must be at a
  // rising edge. With a gap of zero start stays high, ready for the next transaction.
  task automatic send_command(input logic [bba_pkg::OP_W-1:0] op, input int unsigned first,
                              input int unsigned last, input bit value,
                              input int unsigned want, input int gap);
    start       <= 1'b1;
    operation   <= op;
    first_index <= first[bba_pkg::IDX_W-1:0];
    last_index  <= last[bba_pkg::IDX_W-1:0];
    bit_value   <= value;
    run_length  <= want[bba_pkg::CNT_W-1:0];
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_command(op, first, last, value, want));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops issuing commands and waits until every owed result has come back.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Changes the active size; only done once the block has nothing in flight.
  task automatic write_size(input int unsigned value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value[bba_pkg::CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    shadow_size_reg = value & 11'h7FF;
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] expected,
                                      input logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      error_count++;
    end
  endfunction

  // Every done strobe is one result transaction; it is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no command outstanding, actual run_start %0d count %0d",
                 $time, run_start, free_bits);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("bit_read", 32'(want.bit_read), 32'(bit_read));
        check_field("index_valid", 32'(want.index_valid), 32'(index_valid));
        check_field("run_found", 32'(want.run_found), 32'(run_found));
        check_field("run_start", 32'(want.run_start), 32'(run_start));
        check_field("free_bits", 32'(want.free_bits), 32'(free_bits));
        check_field("used_count", 32'(want.used_count), 32'(used_count));
      end
    end
  end

  // Fresh map at the default size: everything is free and a full-length run starts at 0.
  task automatic test_reset_state();
    send_command(bba_pkg::OP_COUNT, 0, 0, 1'b0, 0, 0);
    send_command(bba_pkg::OP_FIND, 0, 0, 1'b0, NBITS, 1);
    send_command(bba_pkg::OP_READ, NBITS - 1, 0, 1'b0, 0, 0);
  endtask

  // Single-bit writes at both ends of the map; the low end is read back.
  task automatic test_single_bits();
    send_command(bba_pkg::OP_WRITE, NBITS - 1, 0, 1'b1, 0, 0);
    send_command(bba_pkg::OP_WRITE, 0, 0, 1'b1, 0, 2);
    send_command(bba_pkg::OP_READ, 0, 0, 1'b0, 0, 0);
  endtask

  // Inverted range, whole map set, upper half cleared; searches just fitting and just missing.
  task automatic test_ranges_and_search();
    send_command(bba_pkg::OP_RANGE, 5, 3, 1'b1, 0, 0);
    send_command(bba_pkg::OP_RANGE, 0, NBITS - 1, 1'b1, 0, 1);
    send_command(bba_pkg::OP_COUNT, 0, 0, 1'b0, 0, 0);
    send_command(bba_pkg::OP_RANGE, NBITS / 2, NBITS - 1, 1'b0, 0, 0);
    send_command(bba_pkg::OP_FIND, 0, 0, 1'b0, NBITS / 2, 3);
    send_command(bba_pkg::OP_FIND, 0, 0, 1'b0, NBITS / 2 + 1, 0);
    send_command(bba_pkg::OP_FIND, 0, 0, 1'b0, 0, 0);
    send_command(bba_pkg::OP_FIND, 0, 0, 1'b0, 2047, 1);
  endtask

  // Reserved operation codes give an all-zero result and change nothing.
  task automatic test_reserved_ops();
    for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
      send_command(op[bba_pkg::OP_W-1:0], 0, NBITS - 1, 1'b1, NBITS, 0);
    send_command(bba_pkg::OP_COUNT, 0, 0, 1'b0, 0, 0);
  endtask

  // Size register at zero, at its largest value and at a single cell.
  task automatic test_size_extremes();
    write_size(0);
    send_command(bba_pkg::OP_READ, 0, 0, 1'b0, 0, 0);
    send_command(bba_pkg::OP_COUNT, 0, 0, 1'b0, 0, 0);
    send_command(bba_pkg::OP_FIND, 0, 0, 1'b0, 1, 0);
    write_size(2047);
    send_command(bba_pkg::OP_COUNT, 0, 0, 1'b0, 0, 0);
    write_size(1);
    send_command(bba_pkg::OP_WRITE, 1, 0, 1'b1, 0, 0);
    send_command(bba_pkg::OP_FIND, 0, 0, 1'b0, 1, 0);
    send_command(bba_pkg::OP_READ, NBITS - 1, 0, 1'b0, 0, 0);
  endtask

  // Mostly inside the active size, sometimes anywhere.
  function automatic int unsigned pick_index();
    if (active_cells() != 0 && $urandom_range(0, 99) < 85)
      return $urandom_range(0, active_cells() - 1);
    return $urandom_range(0, NBITS - 1);
  endfunction

  // Run lengths: mostly small, a few up to the active size, a few anywhere in the field.
  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70)
      return $urandom_range(1, 16);
    if (roll < 90 && active_cells() != 0)
      return $urandom_range(1, active_cells());
    return $urandom_range(0, 2047);
  endfunction

  // Allocator-like traffic: first-fit searches followed by claiming the run found, frees of
  // random ranges, and a share of reads, counts, single writes and unstructured commands.
  task automatic run_traffic(input int items, input bit idle_on);
    int          issued;
    int unsigned roll;
    int unsigned len;
    int unsigned base;
    int unsigned top;
    bit          found;
    int unsigned where;
    issued = 0;
    while (issued < items) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        len = pick_length();
        first_fit(len, found, where);
        send_command(bba_pkg::OP_FIND, $urandom_range(0, NBITS - 1),
                     $urandom_range(0, NBITS - 1), 1'($urandom_range(0, 1)), len,
                     pick_gap(idle_on));
        issued++;
        if (found) begin
          send_command(bba_pkg::OP_RANGE, where, where + len - 1, 1'b1,
                       $urandom_range(0, 2047), pick_gap(idle_on));
          issued++;
        end
      end else if (roll < 55) begin
        base = pick_index();
        top = base + $urandom_range(0, 40);
        if (top > NBITS - 1)
          top = NBITS - 1;
        send_command(bba_pkg::OP_RANGE, base, top, 1'b0, $urandom_range(0, 2047),
                     pick_gap(idle_on));
        issued++;
      end else if (roll < 65) begin
        send_command(bba_pkg::OP_WRITE, pick_index(), $urandom_range(0, NBITS - 1),
                     1'($urandom_range(0, 1)), $urandom_range(0, 2047), pick_gap(idle_on));
        issued++;
      end else if (roll < 77) begin
        send_command(bba_pkg::OP_READ, pick_index(), $urandom_range(0, NBITS - 1),
                     1'($urandom_range(0, 1)), $urandom_range(0, 2047), pick_gap(idle_on));
        issued++;
      end else if (roll < 87) begin
        send_command(bba_pkg::OP_COUNT, $urandom_range(0, NBITS - 1),
                     $urandom_range(0, NBITS - 1), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 2047), pick_gap(idle_on));
        issued++;
      end else begin
        // Noise: any operation code, inverted ranges and out-of-size fields included.
        send_command(bba_pkg::OP_W'($urandom_range(0, 7)), $urandom_range(0, NBITS - 1),
                     $urandom_range(0, NBITS - 1), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 2047), pick_gap(idle_on));
        issued++;
      end
    end
  endtask

  // Random phases over a spread of sizes; two phases run back to back without gaps.
  task automatic test_random_traffic();
    int unsigned sizes [9];
    sizes = '{1024, 2047, 200, 64, 33, 1, 0, 1023, 0};
    sizes[8] = $urandom_range(2, 1024);
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      run_traffic(ITEMS_PER_PHASE, !(p == 3 || p == 7));
    end
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    operation   <= bba_pkg::OP_READ;
    first_index <= '0;
    last_index  <= '0;
    bit_value   <= 1'b0;
    run_length  <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    error_count = 0;
    shadow_size_reg = 32'(bba_pkg::SIZE_RESET);
    foreach (shadow_map[i])
      shadow_map[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_single_bits();
    test_ranges_and_search();
    test_reserved_ops();
    test_size_extremes();
    test_random_traffic();

    // Let the last command finish, then allow a little longer for any stray strobe.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: a correct run finishes well inside this time.
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_datapath.sv
rtl/core/bitmap_block_allocator.sv
rtl/core/bba_checker.sv
tb/testbench.sv
